### hdl/cers_pkg.sv
// ----------------------------------------------------------------------------
// cers_pkg: shared types and constants of the exit retry sequencer
// Phase and status codes, register indexes, reset values and the
// control bundle that the sequencer core hands to the top level.
// ----------------------------------------------------------------------------
package cers_pkg;

    // Sequencer phases, in the encoding seen on the phase port.
    typedef enum logic [2:0] {
        PH_INIT   = 3'd0,
        PH_IDLE   = 3'd1,
        PH_PROBE  = 3'd2,
        PH_POLL   = 3'd3,
        PH_SETTLE = 3'd4,
        PH_INNER  = 3'd5,
        PH_OUTER  = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    // Run status codes.
    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_VERIFIED = 2'd1,
        ST_TIMEOUT  = 2'd2
    } status_t;

    localparam int CNT_W = 16;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t CNT_MAX = '1;

    // Configuration register indexes (byte address / 4).
    localparam logic [1:0] REG_SETTLE_DELAY  = 2'd0;
    localparam logic [1:0] REG_POLL_LIMIT    = 2'd1;
    localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd2;

    // Configuration reset values.
    localparam cnt_t SETTLE_DELAY_RST  = 16'd5;
    localparam cnt_t POLL_LIMIT_RST    = 16'd10;
    localparam cnt_t ATTEMPT_LIMIT_RST = 16'd10;

    // Configuration values seen by the core.
    typedef struct packed {
        cnt_t settle_delay;
        cnt_t poll_limit;
        cnt_t attempt_limit;
    } cfg_t;

    // One result produced for each accepted request.
    typedef struct packed {
        phase_t  phase;
        logic    clear_buffer;
        logic    send_probe;
        logic    send_separator;
        status_t run_status;
        logic    run_done;
    } result_t;

    // Counter increment that holds at the all-ones value.
    function automatic cnt_t sat_inc(input cnt_t v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : cnt_t'(v + 1'b1);
    endfunction

endpackage

### hdl/cers_core.sv
// ----------------------------------------------------------------------------
// cers_core: phase machine and counters of the exit retry sequencer
// Holds the phase, start latch, counters and status. On each accepted
// request it takes one transition and presents the resulting outputs.
// ----------------------------------------------------------------------------
module cers_core
    import cers_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  logic    start_request,
    input  logic    reply_pending,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t  phase_reg, phase_next;
    logic    start_latch_reg, start_latch_next;
    cnt_t    settle_count_reg, settle_count_next;
    cnt_t    poll_count_reg, poll_count_next;
    cnt_t    attempt_count_reg, attempt_count_next;
    status_t status_reg, status_next;

    logic    latch_now;
    logic    take_start;
    logic    settle_over;
    logic    poll_again;
    logic    attempt_again;
    logic    clr;
    logic    probe;
    logic    sep;
    cnt_t    settle_base;
    cnt_t    poll_base;
    cnt_t    attempt_base;

    // Conditions shared by the transition and data logic.
    assign latch_now     = start_latch_reg | start_request;
    assign take_start    = (phase_reg == PH_IDLE) && latch_now;
    assign settle_over   = settle_count_reg > cfg.settle_delay;
    assign poll_again    = poll_count_reg < cfg.poll_limit;
    assign attempt_again = attempt_count_reg < cfg.attempt_limit;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_INIT:   phase_next = PH_IDLE;
            PH_IDLE:   phase_next = latch_now ? PH_SETTLE : PH_IDLE;
            PH_SETTLE: phase_next = settle_over ? PH_PROBE : PH_SETTLE;
            PH_PROBE:  phase_next = PH_POLL;
            PH_POLL:   phase_next = reply_pending ? PH_INNER : PH_DONE;
            PH_INNER:  phase_next = poll_again ? PH_POLL : PH_OUTER;
            PH_OUTER:  phase_next = attempt_again ? PH_SETTLE : PH_DONE;
            PH_DONE:   phase_next = PH_IDLE;
            default:   phase_next = PH_IDLE;
        endcase
    end

    // Strobes and status for the transition taken.
    always_comb
    begin
        clr         = 1'b0;
        probe       = 1'b0;
        sep         = 1'b0;
        status_next = status_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (latch_now)
                begin
                    clr         = 1'b1;
                    status_next = ST_RUNNING;
                end
            end
            PH_PROBE: probe = 1'b1;
            PH_POLL:
            begin
                if (!reply_pending)
                    status_next = ST_VERIFIED;
            end
            PH_INNER: sep = !poll_again;
            PH_OUTER:
            begin
                if (!attempt_again)
                    status_next = ST_TIMEOUT;
            end
            default: ;
        endcase
    end

    // Counters: clear on the transition, then count in the new phase.
    always_comb
    begin
        settle_base  = ((phase_reg == PH_SETTLE) && settle_over) ? '0 : settle_count_reg;
        poll_base    = (take_start || ((phase_reg == PH_OUTER) && attempt_again))
                       ? '0 : poll_count_reg;
        attempt_base = take_start ? '0 : attempt_count_reg;

        settle_count_next  = settle_base;
        poll_count_next    = poll_base;
        attempt_count_next = attempt_base;
        if (phase_next == PH_SETTLE)
            settle_count_next = sat_inc(settle_base);
        else if (phase_next == PH_INNER)
            poll_count_next = sat_inc(poll_base);
        else if (phase_next == PH_OUTER)
            attempt_count_next = sat_inc(attempt_base);

        start_latch_next = latch_now & ~take_start;
    end

    // State registers advance only on an accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_INIT;
            start_latch_reg   <= 1'b0;
            settle_count_reg  <= '0;
            poll_count_reg    <= '0;
            attempt_count_reg <= '0;
            status_reg        <= ST_RUNNING;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            start_latch_reg   <= start_latch_next;
            settle_count_reg  <= settle_count_next;
            poll_count_reg    <= poll_count_next;
            attempt_count_reg <= attempt_count_next;
            status_reg        <= status_next;
        end
    end

    // Result of the transition, registered by the top level.
    always_comb
    begin
        result.phase          = phase_next;
        result.clear_buffer   = clr;
        result.send_probe     = probe;
        result.send_separator = sep;
        result.run_status     = status_next;
        result.run_done       = (phase_next == PH_DONE);
    end

`ifndef SYNTHESIS
    // The phase only moves on an accepted request.
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg))
        else $error("phase changed without a request");

    // A probe is always followed by a poll.
    a_probe_to_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_PROBE) |=> (phase_reg == PH_POLL))
        else $error("probe phase not followed by poll");

    // Starting a run leaves fresh attempt and poll counts.
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && take_start) |=> (attempt_count_reg == '0 && poll_count_reg == '0
                                    && phase_reg == PH_SETTLE))
        else $error("run start did not clear counters");

    // Status reads running throughout an active run.
    a_status_running: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SETTLE || phase_reg == PH_PROBE || phase_reg == PH_POLL
         || phase_reg == PH_INNER || phase_reg == PH_OUTER) |-> (status_reg == ST_RUNNING))
        else $error("status set during an active run");
`endif

endmodule

### hdl/command_exit_retry_sequencer_unit.sv
// ----------------------------------------------------------------------------
// command_exit_retry_sequencer_unit: exit verification retry sequencer
// Each request is one tick with a start flag and a receive-buffer flag;
// each tick yields one result with the phase, command strobes and status.
//
// Usage:
//   Input channel (in_valid/in_stall) carries start_request and
//   reply_pending. Output channel (out_valid/out_stall) carries phase,
//   clear_buffer, send_probe, send_separator, run_status and run_done.
//   Three 16-bit registers on the APB port: settle_delay at 0x0,
//   poll_limit at 0x4, attempt_limit at 0x8; write them only while idle.
//   The result appears in the output register the cycle after its
//   request is accepted. Throughput is one request per cycle while the
//   receiver does not stall the output.
//   When the receiver stalls, the output register holds its result and
//   in_stall rises until the result is taken; no request is lost.
//   Reset puts the sequencer in the init phase with all counters and the
//   status cleared, the registers at their defaults and the output empty.
// ----------------------------------------------------------------------------
module command_exit_retry_sequencer_unit
    import cers_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        start_request,
    input  logic        reply_pending,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  phase,
    output logic        clear_buffer,
    output logic        send_probe,
    output logic        send_separator,
    output logic [1:0]  run_status,
    output logic        run_done,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg_reg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    accept;
    logic    cfg_write;
    logic [1:0] reg_index;

    // Configuration register file.
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_delay  <= SETTLE_DELAY_RST;
            cfg_reg.poll_limit    <= POLL_LIMIT_RST;
            cfg_reg.attempt_limit <= ATTEMPT_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_SETTLE_DELAY:  cfg_reg.settle_delay  <= pwdata[CNT_W-1:0];
                REG_POLL_LIMIT:    cfg_reg.poll_limit    <= pwdata[CNT_W-1:0];
                REG_ATTEMPT_LIMIT: cfg_reg.attempt_limit <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (reg_index)
            REG_SETTLE_DELAY:  prdata = {16'd0, cfg_reg.settle_delay};
            REG_POLL_LIMIT:    prdata = {16'd0, cfg_reg.poll_limit};
            REG_ATTEMPT_LIMIT: prdata = {16'd0, cfg_reg.attempt_limit};
            default:           prdata = '0;
        endcase
    end

    // A request is taken whenever the output register is free or draining.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    cers_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .start_request (start_request),
        .reply_pending (reply_pending),
        .cfg           (cfg_reg),
        .result        (result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result;
    end

    assign out_valid      = out_valid_reg;
    assign phase          = result_reg.phase;
    assign clear_buffer   = result_reg.clear_buffer;
    assign send_probe     = result_reg.send_probe;
    assign send_separator = result_reg.send_separator;
    assign run_status     = result_reg.run_status;
    assign run_done       = result_reg.run_done;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the exit retry sequencer
// Drives start and receive-buffer flags one request per tick, predicts the
// phase, command strobes and status of every tick, and compares each result
// as it leaves the block. A short table walks the success path, the timeout
// path and the start latch corner cases. Random runs then follow under
// several register settings, ending with a long settle delay.
// ----------------------------------------------------------------------------
module testbench;
    import cers_pkg::*;

    // Register index with no register behind it; writes to it are dropped.
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

    // One line of the directed table: a request or a register write.
    typedef struct {
        row_kind_t  kind;
        logic [1:0] reg_idx;
        cnt_t       value;
        logic       sr;
        logic       rp;
        bit         pinned;
        result_t    want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        start_request = 1'b0;
    logic        reply_pending = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  phase;
    logic        clear_buffer;
    logic        send_probe;
    logic        send_separator;
    logic [1:0]  run_status;
    logic        run_done;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Sequencer state as the bench expects it.
    phase_t  seq_phase = PH_INIT;
    logic    seq_latch = 1'b0;
    cnt_t    settle_cnt = '0;
    cnt_t    poll_cnt = '0;
    cnt_t    attempt_cnt = '0;
    status_t seq_status = ST_RUNNING;
    cfg_t    seq_cfg = '{SETTLE_DELAY_RST, POLL_LIMIT_RST, ATTEMPT_LIMIT_RST};

    result_t   tick_results_due[$];
    bit        row_pinned = 1'b0;
    result_t   row_want = '0;
    bit        quiet = 1'b0;
    int        stall_left = 0;
    int        errors = 0;
    stim_row_t directed [26];

    command_exit_retry_sequencer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_request  (start_request),
        .reply_pending  (reply_pending),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase          (phase),
        .clear_buffer   (clear_buffer),
        .send_probe     (send_probe),
        .send_separator (send_separator),
        .run_status     (run_status),
        .run_done       (run_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 clk = ~clk;

    // Counters stop at all ones.
    function automatic cnt_t bump(input cnt_t v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

    // Advance the expected sequencer by one tick and return what it shows.
    task automatic sequencer_tick(input logic sr, input logic rp, output result_t r);
        logic clr;
        logic probe;
        logic sep;
        clr = 1'b0;
        probe = 1'b0;
        sep = 1'b0;
        seq_latch = seq_latch | sr;
        case (seq_phase)
            PH_INIT:
                seq_phase = PH_IDLE;
            PH_IDLE:
                if (seq_latch) begin
                    seq_latch = 1'b0;
                    seq_status = ST_RUNNING;
                    attempt_cnt = '0;
                    poll_cnt = '0;
                    clr = 1'b1;
                    seq_phase = PH_SETTLE;
                end
            PH_SETTLE:
                if (settle_cnt > seq_cfg.settle_delay) begin
                    settle_cnt = '0;
                    seq_phase = PH_PROBE;
                end
            PH_PROBE:
            begin
                probe = 1'b1;
                seq_phase = PH_POLL;
            end
            PH_POLL:
                if (rp) begin
                    seq_phase = PH_INNER;
                end
                else begin
                    seq_status = ST_VERIFIED;
                    seq_phase = PH_DONE;
                end
            PH_INNER:
                if (poll_cnt < seq_cfg.poll_limit) begin
                    seq_phase = PH_POLL;
                end
                else begin
                    sep = 1'b1;
                    seq_phase = PH_OUTER;
                end
            PH_OUTER:
                if (attempt_cnt < seq_cfg.attempt_limit) begin
                    poll_cnt = '0;
                    seq_phase = PH_SETTLE;
                end
                else begin
                    seq_status = ST_TIMEOUT;
                    seq_phase = PH_DONE;
                end
            default:
                seq_phase = PH_IDLE;
        endcase

        // The phase just entered decides which counter moves.
        case (seq_phase)
            PH_SETTLE: settle_cnt = bump(settle_cnt);
            PH_INNER:  poll_cnt = bump(poll_cnt);
            PH_OUTER:  attempt_cnt = bump(attempt_cnt);
            default:   ;
        endcase

        r.phase = seq_phase;
        r.clear_buffer = clr;
        r.send_probe = probe;
        r.send_separator = sep;
        r.run_status = seq_status;
        r.run_done = (seq_phase == PH_DONE);
    endtask

    task automatic check_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Table rows: a plain request, a request with its result typed in,
    // and a register write.
    function automatic stim_row_t req(input logic sr, input logic rp);
        stim_row_t row;
        row = '{ROW_REQ, 2'd0, '0, sr, rp, 1'b0, '0};
        return row;
    endfunction

    function automatic stim_row_t req_pin(input logic sr, input logic rp, input phase_t ph,
                                          input logic clr, input logic probe,
                                          input logic sep, input status_t st,
                                          input logic done);
        stim_row_t row;
        row = req(sr, rp);
        row.pinned = 1'b1;
        row.want = '{ph, clr, probe, sep, st, done};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input cnt_t v);
        stim_row_t row;
        row = '{ROW_CFG, idx, v, 1'b0, 1'b0, 1'b0, '0};
        return row;
    endfunction

    // Offer one request, at times after a random gap, and hold it until taken.
    task automatic send_request(input logic sr, input logic rp, input bit pinned,
                                input result_t want);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        start_request <= sr;
        reply_pending <= rp;
        row_pinned = pinned;
        row_want = want;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Register write once the request stream has drained.
    task automatic write_register(input logic [1:0] idx, input cnt_t value);
        in_valid <= 1'b0;
        while (tick_results_due.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_SETTLE_DELAY:  seq_cfg.settle_delay = value;
            REG_POLL_LIMIT:    seq_cfg.poll_limit = value;
            REG_ATTEMPT_LIMIT: seq_cfg.attempt_limit = value;
            default:           ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Random runs under one setting: start and pending rates in percent.
    task automatic run_random(input cnt_t settle, input cnt_t polls, input cnt_t attempts,
                              input int n, input int start_pct, input int pend_pct);
        write_register(REG_SETTLE_DELAY, settle);
        write_register(REG_POLL_LIMIT, polls);
        write_register(REG_ATTEMPT_LIMIT, attempts);
        repeat (n)
            send_request($urandom_range(0, 99) < start_pct,
                         $urandom_range(0, 99) < pend_pct, 1'b0, '0);
    endtask

    // Receiver stalls in random bursts.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // Check results leaving the block, then predict for requests taken.
    always @(posedge clk) begin : watch
        result_t due;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (tick_results_due.size() == 0) begin
                    $display("%0t: result with no request waiting, phase %0d", $time, phase);
                    errors++;
                end
                else begin
                    due = tick_results_due.pop_front();
                    check_field("phase", due.phase, phase);
                    check_field("clear_buffer", due.clear_buffer, clear_buffer);
                    check_field("send_probe", due.send_probe, send_probe);
                    check_field("send_separator", due.send_separator, send_separator);
                    check_field("run_status", due.run_status, run_status);
                    check_field("run_done", due.run_done, run_done);
                end
            end
            if (in_valid && !in_stall) begin
                sequencer_tick(start_request, reply_pending, due);
                if (row_pinned)
                    due = row_want;
                tick_results_due.push_back(due);
            end
        end
    end

    // Main sequence.
    initial begin
        int i;

        // Success path with a start arriving mid-run, then the timeout path
        // with zero limits and a start on the tick that returns to idle.
        directed = '{
            req_pin(0, 0, PH_IDLE, 0, 0, 0, ST_RUNNING, 0),
            req_pin(0, 1, PH_IDLE, 0, 0, 0, ST_RUNNING, 0),
            req_pin(1, 0, PH_SETTLE, 1, 0, 0, ST_RUNNING, 0),
            req(1, 1),
            req(0, 0),
            req(0, 1),
            req(0, 0),
            req(0, 1),
            req(0, 1),
            req(0, 0),
            req(0, 1),
            req(0, 0),
            req_pin(0, 0, PH_DONE, 0, 0, 0, ST_VERIFIED, 1),
            req(0, 0),
            req(0, 0),
            cfg_row(REG_SETTLE_DELAY, 16'd0),
            cfg_row(REG_POLL_LIMIT, 16'd0),
            cfg_row(REG_ATTEMPT_LIMIT, 16'd0),
            cfg_row(REG_SPARE, 16'hFFFF),
            req(0, 1),
            req(0, 1),
            req(0, 1),
            req(0, 1),
            req_pin(0, 0, PH_DONE, 0, 0, 0, ST_TIMEOUT, 1),
            req(1, 0),
            req(0, 0)
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < $size(directed); i++) begin
            if (directed[i].kind == ROW_CFG)
                write_register(directed[i].reg_idx, directed[i].value);
            else
                send_request(directed[i].sr, directed[i].rp, directed[i].pinned,
                             directed[i].want);
        end

        // Random runs under several settings, limits from zero up to 65534.
        run_random(16'd2, 16'd3, 16'd2, 160, 15, 85);
        run_random(16'd0, 16'd0, 16'd0, 140, 20, 50);
        run_random(16'd1, 16'd1, 16'd4, 160, 10, 90);
        run_random(16'($urandom_range(0, 8)), 16'($urandom_range(0, 5)),
                   16'($urandom_range(0, 5)), 160, 15, 80);
        run_random(16'd0, 16'd65534, 16'd65534, 160, 15, 70);
        run_random(16'd5, 16'd10, 16'd10, 150, 12, 75);

        // Last part without idling: return to idle, then one run with a
        // long settle delay.
        quiet = 1'b1;
        while (seq_phase != PH_IDLE)
            send_request(1'b0, 1'b0, 1'b0, '0);
        write_register(REG_SETTLE_DELAY, 16'd40);
        write_register(REG_POLL_LIMIT, 16'd2);
        write_register(REG_ATTEMPT_LIMIT, 16'd1);
        send_request(1'b1, 1'b0, 1'b0, '0);
        while (seq_phase != PH_DONE)
            send_request(1'b0, $urandom_range(0, 3) == 0, 1'b0, '0);
        repeat (3)
            send_request(1'b0, 1'b0, 1'b0, '0);

        // Drain and finish.
        in_valid <= 1'b0;
        while (tick_results_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
